FILE: rtl/bsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg: shared definitions for the byte-stuffing deframer
// Holds the deframer state codes, the result kinds, the configuration
// register indexes and their reset values.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Deframer state.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FRAME = 2'd1,
    ST_ESC   = 2'd2
  } frame_state_e;

  // Kind of one result transaction.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START_FLAG  = 2'd0,
    CFG_END_FLAG    = 2'd1,
    CFG_ESCAPE_FLAG = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ByteW   = 8;

  localparam logic [ByteW-1:0] StartFlagRst  = 8'd126;
  localparam logic [ByteW-1:0] EndFlagRst    = 8'd125;
  localparam logic [ByteW-1:0] EscapeFlagRst = 8'd124;

endpackage

FILE: rtl/bsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_in_if: received byte channel
// Valid/ready channel that carries one raw byte of the stuffed stream.
// ----------------------------------------------------------------------------
interface bsd_in_if
  import bsd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/bsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_out_if: deframer result channel
// Valid/ready channel that carries one result kind and an unstuffed byte.
// ----------------------------------------------------------------------------
interface bsd_out_if
  import bsd_pkg::*;
();
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [ByteW-1:0] payload_byte;

  modport source (output valid, output kind, output payload_byte, input ready);
  modport sink   (input valid, input kind, input payload_byte, output ready);
endinterface

FILE: rtl/byte_stuffing_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffing_deframer: byte-stuffed stream deframer
// Removes start, end and escape bytes from a received stream and reports
// data bytes, frame completion and framing errors.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake       Payload
//  in_if    sink       valid / ready   rx_byte (8 bit)
//  out_if   source     valid / ready   kind (2 bit), payload_byte (8 bit)
//  cfg      input      cfg_we_i        cfg_idx_i (2 bit), cfg_data_i (8 bit)
//
// One byte is accepted per cycle unless a result stalls; the result of a byte
// passes through the input register, then the result register.
// The deframer state updates once per byte, when the byte leaves the input
// register, so the single state register sets the one-byte-per-cycle rate.
// Reset clears the state to idle and loads the default flag values.
// A stalled result holds the input register only if that byte has a result;
// bytes without a result keep flowing.
// ----------------------------------------------------------------------------
module byte_stuffing_deframer
  import bsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  bsd_in_if.sink             in_if,
  bsd_out_if.source          out_if
);

  logic [ByteW-1:0] start_flag_q, end_flag_q, escape_flag_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  frame_state_e     state_q, state_d;
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [ByteW-1:0] out_byte_q;

  logic             res_valid;
  kind_e            res_kind;
  logic [ByteW-1:0] res_byte;
  logic             out_free;
  logic             in_drain;
  logic             out_load;
  logic             in_take;
  logic             is_start, is_end, is_esc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_flag_q  <= StartFlagRst;
      end_flag_q    <= EndFlagRst;
      escape_flag_q <= EscapeFlagRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_FLAG:  start_flag_q  <= cfg_data_i;
        CFG_END_FLAG:    end_flag_q    <= cfg_data_i;
        CFG_ESCAPE_FLAG: escape_flag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flag compares on the registered byte.
  assign is_start = (in_byte_q == start_flag_q);
  assign is_end   = (in_byte_q == end_flag_q);
  assign is_esc   = (in_byte_q == escape_flag_q);

  // Handshake between the input register and the result register.
  assign out_free    = !out_valid_q || out_if.ready;
  assign in_drain    = in_valid_q && (!res_valid || out_free);
  assign out_load    = in_drain && res_valid;
  assign in_if.ready = !in_valid_q || in_drain;
  assign in_take     = in_if.valid && in_if.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    if (in_drain) begin
      unique case (state_q)
        ST_FRAME: begin
          if (is_esc) begin
            state_d = ST_ESC;
          end else if (is_end) begin
            state_d = ST_IDLE;
          end
        end
        ST_ESC: begin
          state_d = (is_start || is_end || is_esc) ? ST_FRAME : ST_IDLE;
        end
        default: begin
          state_d = is_start ? ST_FRAME : ST_IDLE;
        end
      endcase
    end
  end

  // Result for the byte in the input register.
  always_comb begin
    res_valid = 1'b1;
    res_kind  = KIND_ERROR;
    res_byte  = '0;
    unique case (state_q)
      ST_FRAME: begin
        if (is_esc) begin
          res_valid = 1'b0;
        end else if (is_end) begin
          res_kind = KIND_DONE;
        end else begin
          res_kind = KIND_DATA;
          res_byte = in_byte_q;
        end
      end
      ST_ESC: begin
        if (is_start || is_end || is_esc) begin
          res_kind = KIND_DATA;
          res_byte = in_byte_q;
        end
      end
      default: begin
        if (is_start) begin
          res_valid = 1'b0;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_if.rx_byte;
    end
    if (out_load) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.kind         = out_kind_q;
  assign out_if.payload_byte = out_byte_q;

`ifndef ASSERT_OFF
  // A byte waiting for a full result register stays in place.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_drain |=> in_valid_q && $stable(in_byte_q))
    else $error("input register changed while stalled");

  // An error result always returns the deframer to idle.
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_kind == KIND_ERROR) |=> state_q == ST_IDLE)
    else $error("error result did not return to idle");

  // Frame completion comes only from inside a frame.
  a_done_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_kind == KIND_DONE) |-> state_q == ST_FRAME)
    else $error("frame completion outside a frame");

  // Non-data results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q != KIND_DATA) |-> out_byte_q == '0)
    else $error("non-data result with nonzero byte");

  // The input side stalls only when the input register is occupied.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> in_valid_q && res_valid && out_valid_q)
    else $error("input stalled without cause");
`endif

endmodule
